/* rtl/dsc_pkg.sv */
// ----------------------------------------------------------------------------
// Debug stop controller package
// Command and reason codes, plan kinds and the item types shared by the
// stages of the debug stop controller.
// ----------------------------------------------------------------------------
package dsc_pkg;

    localparam int DEFAULT_COUNT_WIDTH = 32;

    localparam logic [3:0] CMD_ARM        = 4'd0;
    localparam logic [3:0] CMD_CLEAR      = 4'd1;
    localparam logic [3:0] CMD_RESET      = 4'd2;
    localparam logic [3:0] CMD_OBSERVE    = 4'd3;
    localparam logic [3:0] CMD_RUN_DONE   = 4'd4;
    localparam logic [3:0] CMD_DONE_BREAK = 4'd5;
    localparam logic [3:0] CMD_DONE_WATCH = 4'd6;
    localparam logic [3:0] CMD_TAKE       = 4'd7;
    localparam logic [3:0] CMD_BUDGET     = 4'd8;

    localparam logic [1:0] KIND_NONE         = 2'd0;
    localparam logic [1:0] KIND_TRACE        = 2'd1;
    localparam logic [1:0] KIND_BREAK_REAL   = 2'd2;
    localparam logic [1:0] KIND_BREAK_LINEAR = 2'd3;

    localparam logic [1:0] REASON_NONE  = 2'd0;
    localparam logic [1:0] REASON_BREAK = 2'd1;
    localparam logic [1:0] REASON_WATCH = 2'd2;
    localparam logic [1:0] REASON_TRACE = 2'd3;

    typedef struct packed {
        logic [3:0]  command;
        logic [1:0]  plan_kind;
        logic [31:0] trace_count;
        logic [31:0] break_address;
        logic [31:0] code_base;
        logic [31:0] instruction_offset;
        logic        watch_match;
        logic [31:0] amount;
    } t_item;

    typedef struct packed {
        logic        status;
        logic [31:0] budget;
        logic        breakpoint_due;
        logic        stop_pending;
        logic [1:0]  stop_reason;
        logic [31:0] stop_count;
        logic        taken;
    } t_result;

endpackage

/* rtl/debug_stop_controller.sv */
// ----------------------------------------------------------------------------
// Debug stop controller
// Keeps the debug plan of a processor (trace or breakpoint), the last
// observed instruction and one pending stop, and answers each command item
// with exactly one result item.
//
// Command items enter on the input channel (i_in_valid, o_in_stall) and
// results leave on the output channel (o_out_valid, i_out_stall). An item
// is moved at a clock edge where valid is high and stall is low.
// An accepted item is held in the input register, processed combinationally
// against the plan and observation registers, and written to the result
// register when that register is empty or its item is being taken.
// One item is accepted per cycle as long as the receiver takes results.
// When the receiver stalls, the result register holds its item, the input
// register takes one more item only if it is empty, and o_in_stall then
// stays high until the result is taken. Synchronous reset empties both
// registers and clears the plan, the observation and any pending stop.
// ----------------------------------------------------------------------------
module debug_stop_controller
    import dsc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_command,
    input  logic [1:0]  i_plan_kind,
    input  logic [31:0] i_trace_count,
    input  logic [31:0] i_break_address,
    input  logic [31:0] i_code_base,
    input  logic [31:0] i_instruction_offset,
    input  logic        i_watch_match,
    input  logic [31:0] i_amount,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [31:0] o_budget,
    output logic        o_breakpoint_due,
    output logic        o_stop_pending,
    output logic [1:0]  o_stop_reason,
    output logic [31:0] o_stop_count,
    output logic        o_taken
);

    t_item   w_in_item;
    t_item   w_s1_item;
    logic    w_s1_valid;
    logic    w_advance;
    t_result w_core_result;
    t_result w_out_result;

    always_comb begin
        w_in_item.command            = i_command;
        w_in_item.plan_kind          = i_plan_kind;
        w_in_item.trace_count        = i_trace_count;
        w_in_item.break_address      = i_break_address;
        w_in_item.code_base          = i_code_base;
        w_in_item.instruction_offset = i_instruction_offset;
        w_in_item.watch_match        = i_watch_match;
        w_in_item.amount             = i_amount;
    end

    dsc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_stall   (o_in_stall),
        .o_valid   (w_s1_valid),
        .o_item    (w_s1_item)
    );

    dsc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_s1_valid && w_advance),
        .i_item   (w_s1_item),
        .o_result (w_core_result)
    );

    dsc_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_s1_valid),
        .i_result  (w_core_result),
        .i_stall   (i_out_stall),
        .o_advance (w_advance),
        .o_valid   (o_out_valid),
        .o_result  (w_out_result)
    );

    assign o_status         = w_out_result.status;
    assign o_budget         = w_out_result.budget;
    assign o_breakpoint_due = w_out_result.breakpoint_due;
    assign o_stop_pending   = w_out_result.stop_pending;
    assign o_stop_reason    = w_out_result.stop_reason;
    assign o_stop_count     = w_out_result.stop_count;
    assign o_taken          = w_out_result.taken;

endmodule

/* rtl/dsc_in_stage.sv */
// ----------------------------------------------------------------------------
// Debug stop controller input register
// Holds one accepted command item until the core consumes it.
// ----------------------------------------------------------------------------
module dsc_in_stage
    import dsc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_load;

    assign w_load  = !r_valid || i_advance;
    assign o_stall = !w_load;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

/* rtl/dsc_core.sv */
// ----------------------------------------------------------------------------
// Debug stop controller core
// Holds the plan, the observation and the pending stop, and works out the
// next state and the result of one command item.
// ----------------------------------------------------------------------------
module dsc_core
    import dsc_pkg::*;
#(
    parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int IN_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

    logic [1:0]             r_kind, n_kind;
    logic [COUNT_WIDTH-1:0] r_rem, n_rem;
    logic [COUNT_WIDTH-1:0] r_exec, n_exec;
    logic [31:0]            r_target, n_target;
    logic                   r_pend_flag, n_pend_flag;
    logic [1:0]             r_pend_reason, n_pend_reason;
    logic [COUNT_WIDTH-1:0] r_pend_count, n_pend_count;
    logic [31:0]            r_seen_base, n_seen_base;
    logic [31:0]            r_seen_off, n_seen_off;
    logic                   r_seen_watch, n_seen_watch;
    logic                   r_seen_valid, n_seen_valid;

    logic [COUNT_WIDTH-1:0] w_amount;
    logic [COUNT_WIDTH-1:0] w_tcount;
    logic [COUNT_WIDTH:0]   w_sum;
    logic [COUNT_WIDTH-1:0] w_sat;
    logic                   w_is_break;
    logic [COUNT_WIDTH-1:0] w_budget;
    logic [COUNT_WIDTH-1:0] w_scount;
    logic                   w_status;
    logic                   w_taken;
    logic                   w_took;
    logic [1:0]             w_took_reason;
    logic [31:0]            w_linear;

    assign w_amount   = COUNT_WIDTH'(i_item.amount[IN_W-1:0]);
    assign w_tcount   = COUNT_WIDTH'(i_item.trace_count[IN_W-1:0]);
    assign w_sum      = {1'b0, r_exec} + {1'b0, w_amount};
    assign w_sat      = w_sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : w_sum[COUNT_WIDTH-1:0];
    assign w_is_break = (r_kind == KIND_BREAK_REAL) || (r_kind == KIND_BREAK_LINEAR);

    always_comb begin
        n_kind        = r_kind;
        n_rem         = r_rem;
        n_exec        = r_exec;
        n_target      = r_target;
        n_pend_flag   = r_pend_flag;
        n_pend_reason = r_pend_reason;
        n_pend_count  = r_pend_count;
        n_seen_base   = r_seen_base;
        n_seen_off    = r_seen_off;
        n_seen_watch  = r_seen_watch;
        n_seen_valid  = r_seen_valid;
        w_status      = 1'b0;
        w_budget      = '0;
        w_scount      = '0;
        w_taken       = 1'b0;
        w_took        = 1'b0;
        w_took_reason = REASON_NONE;
        case (i_item.command)
            CMD_ARM: begin
                if ((i_item.plan_kind == KIND_NONE) ||
                    ((i_item.plan_kind == KIND_TRACE) && (w_tcount == '0))) begin
                    w_status = 1'b1;
                end else begin
                    n_kind        = i_item.plan_kind;
                    n_rem         = w_tcount;
                    n_exec        = '0;
                    n_target      = i_item.break_address;
                    n_pend_flag   = 1'b0;
                    n_pend_reason = REASON_NONE;
                    n_pend_count  = '0;
                end
            end
            CMD_CLEAR, CMD_RESET: begin
                n_kind        = KIND_NONE;
                n_rem         = '0;
                n_exec        = '0;
                n_target      = '0;
                n_pend_flag   = 1'b0;
                n_pend_reason = REASON_NONE;
                n_pend_count  = '0;
                if (i_item.command == CMD_RESET) begin
                    n_seen_base  = '0;
                    n_seen_off   = '0;
                    n_seen_watch = 1'b0;
                    n_seen_valid = 1'b0;
                end
            end
            CMD_OBSERVE: begin
                n_seen_base  = i_item.code_base;
                n_seen_off   = i_item.instruction_offset;
                n_seen_watch = i_item.watch_match;
                n_seen_valid = 1'b1;
            end
            CMD_RUN_DONE: begin
                if (w_amount != '0) begin
                    if (w_is_break) begin
                        n_exec = w_sat;
                    end else if (r_kind == KIND_TRACE) begin
                        n_exec = w_sat;
                        if (w_amount < r_rem) begin
                            n_rem = r_rem - w_amount;
                        end else begin
                            n_pend_flag   = 1'b1;
                            n_pend_reason = REASON_TRACE;
                            n_pend_count  = w_sat;
                            n_kind        = KIND_NONE;
                        end
                    end
                end
            end
            CMD_DONE_BREAK: begin
                if (w_is_break) begin
                    n_pend_flag   = 1'b1;
                    n_pend_reason = REASON_BREAK;
                    n_pend_count  = r_exec;
                    n_kind        = KIND_NONE;
                end
            end
            CMD_DONE_WATCH: begin
                if (r_seen_valid && r_seen_watch) begin
                    n_kind        = KIND_NONE;
                    n_rem         = '0;
                    n_exec        = '0;
                    n_target      = '0;
                    n_pend_flag   = 1'b1;
                    n_pend_reason = REASON_WATCH;
                    n_pend_count  = r_exec;
                end
            end
            CMD_TAKE: begin
                w_took = 1'b1;
                if (r_pend_flag) begin
                    w_taken       = 1'b1;
                    w_took_reason = r_pend_reason;
                    w_scount      = r_pend_count;
                    n_pend_flag   = 1'b0;
                    n_pend_reason = REASON_NONE;
                    n_pend_count  = '0;
                end
            end
            CMD_BUDGET: begin
                if (w_amount == '0) begin
                    w_budget = '0;
                end else if ((r_kind == KIND_TRACE) && (r_rem < w_amount)) begin
                    w_budget = r_rem;
                end else if (w_is_break) begin
                    w_budget = COUNT_WIDTH'(1);
                end else begin
                    w_budget = w_amount;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_linear = n_seen_base + n_seen_off;

    always_comb begin
        o_result.status         = w_status;
        o_result.budget         = 32'(w_budget);
        o_result.breakpoint_due = n_seen_valid && n_kind[1] && (w_linear == n_target);
        o_result.stop_pending   = n_pend_flag;
        o_result.stop_reason    = w_took ? w_took_reason : n_pend_reason;
        o_result.stop_count     = 32'(w_scount);
        o_result.taken          = w_taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind        <= KIND_NONE;
            r_rem         <= '0;
            r_exec        <= '0;
            r_target      <= '0;
            r_pend_flag   <= 1'b0;
            r_pend_reason <= REASON_NONE;
            r_pend_count  <= '0;
            r_seen_base   <= '0;
            r_seen_off    <= '0;
            r_seen_watch  <= 1'b0;
            r_seen_valid  <= 1'b0;
        end else if (i_fire) begin
            r_kind        <= n_kind;
            r_rem         <= n_rem;
            r_exec        <= n_exec;
            r_target      <= n_target;
            r_pend_flag   <= n_pend_flag;
            r_pend_reason <= n_pend_reason;
            r_pend_count  <= n_pend_count;
            r_seen_base   <= n_seen_base;
            r_seen_off    <= n_seen_off;
            r_seen_watch  <= n_seen_watch;
            r_seen_valid  <= n_seen_valid;
        end
    end

    // A pending stop always carries a reason, and no reason is kept without one.
    a_pend_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_flag == (r_pend_reason != REASON_NONE))
        else $error("pending flag and reason disagree");

    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_item.command == CMD_TAKE)) |=> !r_pend_flag)
        else $error("take left a stop pending");

    a_status_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_result.status) |=> $stable(r_kind) && $stable(r_pend_flag))
        else $error("refused arm changed the plan");

    a_taken_only_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.taken || (o_result.stop_count != '0)) |-> (i_item.command == CMD_TAKE))
        else $error("stop reported outside a take");

endmodule

/* rtl/dsc_out_stage.sv */
// ----------------------------------------------------------------------------
// Debug stop controller result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module dsc_out_stage
    import dsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

/* sim/debug_stop_controller_checker.sv */
// ----------------------------------------------------------------------------
// Debug stop controller checker
// Watches both channels of the debug stop controller. For every accepted
// command item it predicts the result from its own copy of the plan, the
// observation and the pending stop, queues it, and compares every result
// item that leaves the block field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module debug_stop_controller_checker
    import dsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [3:0]  i_command,
    input  logic [1:0]  i_plan_kind,
    input  logic [31:0] i_trace_count,
    input  logic [31:0] i_break_address,
    input  logic [31:0] i_code_base,
    input  logic [31:0] i_instruction_offset,
    input  logic        i_watch_match,
    input  logic [31:0] i_amount,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_status,
    input  logic [31:0] i_budget,
    input  logic        i_breakpoint_due,
    input  logic        i_stop_pending,
    input  logic [1:0]  i_stop_reason,
    input  logic [31:0] i_stop_count,
    input  logic        i_taken,
    output int          o_errors,
    output int          o_outstanding
);

    logic [1:0]  plan;
    logic [31:0] trace_left;
    logic [31:0] exec_total;
    logic [31:0] break_target;
    logic        stop_flag;
    logic [1:0]  stop_why;
    logic [31:0] stop_at;
    logic [31:0] obs_base;
    logic [31:0] obs_offset;
    logic        obs_watch;
    logic        obs_valid;

    t_result expected_results[$];
    int      fail_count = 0;

    function automatic logic plan_is_break();
        return plan == KIND_BREAK_REAL || plan == KIND_BREAK_LINEAR;
    endfunction

    task automatic clear_plan();
        plan         = KIND_NONE;
        trace_left   = '0;
        exec_total   = '0;
        break_target = '0;
        stop_flag    = 1'b0;
        stop_why     = REASON_NONE;
        stop_at      = '0;
    endtask

    task automatic clear_all();
        clear_plan();
        obs_base   = '0;
        obs_offset = '0;
        obs_watch  = 1'b0;
        obs_valid  = 1'b0;
    endtask

    task automatic add_executed(input logic [31:0] count);
        logic [32:0] sum;
        sum        = {1'b0, exec_total} + {1'b0, count};
        exec_total = sum[32] ? '1 : sum[31:0];
    endtask

    task automatic predict_step(input t_item it, output t_result r);
        logic [31:0] held_total;
        logic [31:0] linear;
        logic        took;
        logic [1:0]  took_reason;
        r           = '0;
        took        = 1'b0;
        took_reason = REASON_NONE;
        case (it.command)
            CMD_ARM: begin
                if (it.plan_kind == KIND_NONE ||
                    (it.plan_kind == KIND_TRACE && it.trace_count == '0)) begin
                    r.status = 1'b1;
                end else begin
                    clear_plan();
                    plan         = it.plan_kind;
                    trace_left   = it.trace_count;
                    break_target = it.break_address;
                end
            end
            CMD_CLEAR: clear_plan();
            CMD_RESET: clear_all();
            CMD_OBSERVE: begin
                obs_base   = it.code_base;
                obs_offset = it.instruction_offset;
                obs_watch  = it.watch_match;
                obs_valid  = 1'b1;
            end
            CMD_RUN_DONE: begin
                if (it.amount != '0 && plan != KIND_NONE) begin
                    add_executed(it.amount);
                    if (plan == KIND_TRACE) begin
                        if (it.amount < trace_left) begin
                            trace_left = trace_left - it.amount;
                        end else begin
                            stop_flag = 1'b1;
                            stop_why  = REASON_TRACE;
                            stop_at   = exec_total;
                            plan      = KIND_NONE;
                        end
                    end
                end
            end
            CMD_DONE_BREAK: begin
                if (plan_is_break()) begin
                    stop_flag = 1'b1;
                    stop_why  = REASON_BREAK;
                    stop_at   = exec_total;
                    plan      = KIND_NONE;
                end
            end
            CMD_DONE_WATCH: begin
                if (obs_valid && obs_watch) begin
                    held_total = exec_total;
                    clear_plan();
                    stop_flag = 1'b1;
                    stop_why  = REASON_WATCH;
                    stop_at   = held_total;
                end
            end
            CMD_TAKE: begin
                took = 1'b1;
                if (stop_flag) begin
                    r.taken      = 1'b1;
                    took_reason  = stop_why;
                    r.stop_count = stop_at;
                    stop_flag    = 1'b0;
                    stop_why     = REASON_NONE;
                    stop_at      = '0;
                end
            end
            CMD_BUDGET: begin
                if (it.amount == '0) begin
                    r.budget = '0;
                end else if (plan == KIND_TRACE && trace_left < it.amount) begin
                    r.budget = trace_left;
                end else if (plan_is_break()) begin
                    r.budget = 32'd1;
                end else begin
                    r.budget = it.amount;
                end
            end
            default: ;
        endcase
        linear           = obs_base + obs_offset;
        r.breakpoint_due = obs_valid && plan_is_break() && linear == break_target;
        r.stop_pending   = stop_flag;
        r.stop_reason    = took ? took_reason : stop_why;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item   it;
        t_result want;
        if (!i_rst_n) begin
            clear_all();
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result item arrived with no command item waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 32'(want.status), 32'(i_status));
                    check_field("budget", want.budget, i_budget);
                    check_field("breakpoint_due", 32'(want.breakpoint_due),
                                32'(i_breakpoint_due));
                    check_field("stop_pending", 32'(want.stop_pending), 32'(i_stop_pending));
                    check_field("stop_reason", 32'(want.stop_reason), 32'(i_stop_reason));
                    check_field("stop_count", want.stop_count, i_stop_count);
                    check_field("taken", 32'(want.taken), 32'(i_taken));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                it.command            = i_command;
                it.plan_kind          = i_plan_kind;
                it.trace_count        = i_trace_count;
                it.break_address      = i_break_address;
                it.code_base          = i_code_base;
                it.instruction_offset = i_instruction_offset;
                it.watch_match        = i_watch_match;
                it.amount             = i_amount;
                predict_step(it, want);
                expected_results.push_back(want);
            end
        end
        o_errors      <= fail_count;
        o_outstanding <= expected_results.size();
    end

endmodule

/* sim/debug_stop_controller_tb.sv */
// ----------------------------------------------------------------------------
// Debug stop controller testbench
// Drives command items into the debug stop controller with random gaps,
// stalls the result side at random and once for a long stretch, and leaves
// prediction and comparison to the checker. A directed opening covers the
// refused arms, wrapping breakpoint addresses, saturation of the executed
// total, trace stops, watchpoints and unused codes; random command
// sequences follow.
// ----------------------------------------------------------------------------
module debug_stop_controller_tb;
    import dsc_pkg::*;

    localparam int          RESET_CYCLES   = 9;
    localparam int          RANDOM_ITEMS   = 425;
    localparam int          HOLD_AFTER     = 120;
    localparam int          HOLD_CYCLES    = 60;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [3:0]  CMD_UNUSED_LO  = CMD_BUDGET + 4'd1;
    localparam logic [3:0]  CMD_UNUSED_HI  = 4'hF;
    localparam logic [31:0] ALL_ONES       = '1;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [3:0]  i_command;
    logic [1:0]  i_plan_kind;
    logic [31:0] i_trace_count;
    logic [31:0] i_break_address;
    logic [31:0] i_code_base;
    logic [31:0] i_instruction_offset;
    logic        i_watch_match;
    logic [31:0] i_amount;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_status;
    logic [31:0] o_budget;
    logic        o_breakpoint_due;
    logic        o_stop_pending;
    logic [1:0]  o_stop_reason;
    logic [31:0] o_stop_count;
    logic        o_taken;

    int          errors;
    int          outstanding;
    int          items_accepted = 0;
    int          results_seen   = 0;
    int          stops_taken[4] = '{0, 0, 0, 0};
    int          idle_cycles    = 0;
    logic        no_gaps        = 1'b0;
    logic [31:0] armed_target   = '0;

    always #5 i_clk = ~i_clk;

    debug_stop_controller dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_command            (i_command),
        .i_plan_kind          (i_plan_kind),
        .i_trace_count        (i_trace_count),
        .i_break_address      (i_break_address),
        .i_code_base          (i_code_base),
        .i_instruction_offset (i_instruction_offset),
        .i_watch_match        (i_watch_match),
        .i_amount             (i_amount),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_status             (o_status),
        .o_budget             (o_budget),
        .o_breakpoint_due     (o_breakpoint_due),
        .o_stop_pending       (o_stop_pending),
        .o_stop_reason        (o_stop_reason),
        .o_stop_count         (o_stop_count),
        .o_taken              (o_taken)
    );

    debug_stop_controller_checker u_check (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .i_in_stall           (o_in_stall),
        .i_command            (i_command),
        .i_plan_kind          (i_plan_kind),
        .i_trace_count        (i_trace_count),
        .i_break_address      (i_break_address),
        .i_code_base          (i_code_base),
        .i_instruction_offset (i_instruction_offset),
        .i_watch_match        (i_watch_match),
        .i_amount             (i_amount),
        .i_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .i_status             (o_status),
        .i_budget             (o_budget),
        .i_breakpoint_due     (o_breakpoint_due),
        .i_stop_pending       (o_stop_pending),
        .i_stop_reason        (o_stop_reason),
        .i_stop_count         (o_stop_count),
        .i_taken              (o_taken),
        .o_errors             (errors),
        .o_outstanding        (outstanding)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                items_accepted <= items_accepted + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (o_taken) begin
                    stops_taken[o_stop_reason] <= stops_taken[o_stop_reason] + 1;
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
                $display("debug_stop_controller: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : result_side
        int n_free;
        int n_stall;
        int pick;
        logic held;
        held = 1'b0;
        i_out_stall <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && items_accepted >= HOLD_AFTER) begin
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            pick   = $urandom_range(99);
            n_free = (pick < 15) ? $urandom_range(40, 10) : 1;
            i_out_stall <= 1'b0;
            repeat (n_free) @(posedge i_clk);
            pick = $urandom_range(99);
            if (pick < 45) begin
                n_stall = 0;
            end else if (pick < 90) begin
                n_stall = $urandom_range(3, 1);
            end else begin
                n_stall = $urandom_range(30, 8);
            end
            if (n_stall > 0) begin
                i_out_stall <= 1'b1;
                repeat (n_stall) @(posedge i_clk);
            end
        end
    end

    function automatic t_item make_item(input logic [3:0] cmd, input logic [1:0] kind,
                                        input logic [31:0] count, input logic [31:0] addr,
                                        input logic [31:0] base, input logic [31:0] offset,
                                        input logic watch, input logic [31:0] amt);
        t_item it;
        it.command            = cmd;
        it.plan_kind          = kind;
        it.trace_count        = count;
        it.break_address      = addr;
        it.code_base          = base;
        it.instruction_offset = offset;
        it.watch_match        = watch;
        it.amount             = amt;
        return it;
    endfunction

    function automatic logic [31:0] random_amount();
        int pick;
        pick = $urandom_range(99);
        if (pick < 15) return '0;
        if (pick < 75) return $urandom_range(8, 1);
        if (pick < 85) return ALL_ONES - $urandom_range(3);
        return $urandom;
    endfunction

    function automatic t_item random_command();
        t_item it;
        int pick;
        it = make_item(4'($urandom), 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                       1'($urandom), $urandom);
        pick = $urandom_range(99);
        if (pick < 10) begin
            if ($urandom_range(1)) begin
                it.command = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
            end
            return it;
        end
        if (pick < 22) begin
            it.command   = CMD_ARM;
            it.plan_kind = ($urandom_range(19) == 0) ? KIND_NONE
                           : 2'($urandom_range(KIND_BREAK_LINEAR, KIND_TRACE));
            pick = $urandom_range(99);
            if (pick < 10) begin
                it.trace_count = '0;
            end else if (pick < 80) begin
                it.trace_count = $urandom_range(12, 1);
            end
        end else if (pick < 34) begin
            it.command = CMD_OBSERVE;
            if ($urandom_range(1)) it.instruction_offset = armed_target - it.code_base;
        end else if (pick < 55) begin
            it.command = CMD_RUN_DONE;
            it.amount  = random_amount();
        end else if (pick < 62) begin
            it.command = CMD_DONE_BREAK;
        end else if (pick < 68) begin
            it.command = CMD_DONE_WATCH;
        end else if (pick < 80) begin
            it.command = CMD_TAKE;
        end else if (pick < 92) begin
            it.command = CMD_BUDGET;
            it.amount  = $urandom_range(1) ? $urandom_range(15) : random_amount();
        end else if (pick < 97) begin
            it.command = CMD_CLEAR;
        end else begin
            it.command = CMD_RESET;
        end
        return it;
    endfunction

    task automatic issue_command(input t_item it);
        int n_gap;
        int pick;
        i_in_valid           <= 1'b1;
        i_command            <= it.command;
        i_plan_kind          <= it.plan_kind;
        i_trace_count        <= it.trace_count;
        i_break_address      <= it.break_address;
        i_code_base          <= it.code_base;
        i_instruction_offset <= it.instruction_offset;
        i_watch_match        <= it.watch_match;
        i_amount             <= it.amount;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pick = $urandom_range(99);
        if (no_gaps || pick < 55) begin
            n_gap = 0;
        end else if (pick < 90) begin
            n_gap = $urandom_range(3, 1);
        end else begin
            n_gap = $urandom_range(25, 6);
        end
        if (n_gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (n_gap) @(posedge i_clk);
        end
    endtask

    initial begin : command_side
        t_item it;
        i_rst_n              <= 1'b0;
        i_in_valid           <= 1'b0;
        i_command            <= CMD_BUDGET;
        i_plan_kind          <= KIND_NONE;
        i_trace_count        <= '0;
        i_break_address      <= '0;
        i_code_base          <= '0;
        i_instruction_offset <= '0;
        i_watch_match        <= 1'b0;
        i_amount             <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_command(make_item(CMD_BUDGET, KIND_NONE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_BUDGET, KIND_NONE, 0, 0, 0, 0, 1'b0, ALL_ONES));
        issue_command(make_item(CMD_ARM, KIND_NONE, 5, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_ARM, KIND_TRACE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_OBSERVE, KIND_NONE, 0, 0, ALL_ONES, 1, 1'b0, 0));
        issue_command(make_item(CMD_ARM, KIND_BREAK_LINEAR, ALL_ONES, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_BUDGET, KIND_NONE, 0, 0, 0, 0, 1'b0, 5));
        issue_command(make_item(CMD_RUN_DONE, KIND_NONE, 0, 0, 0, 0, 1'b0, ALL_ONES - 1));
        issue_command(make_item(CMD_RUN_DONE, KIND_NONE, 0, 0, 0, 0, 1'b0, 7));
        issue_command(make_item(CMD_RUN_DONE, KIND_NONE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_DONE_BREAK, KIND_NONE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_DONE_BREAK, KIND_NONE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_ARM, KIND_TRACE, 3, ALL_ONES, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_BUDGET, KIND_NONE, 0, 0, 0, 0, 1'b0, 10));
        issue_command(make_item(CMD_BUDGET, KIND_NONE, 0, 0, 0, 0, 1'b0, 2));
        issue_command(make_item(CMD_RUN_DONE, KIND_NONE, 0, 0, 0, 0, 1'b0, 2));
        issue_command(make_item(CMD_RUN_DONE, KIND_NONE, 0, 0, 0, 0, 1'b0, 1));
        issue_command(make_item(CMD_TAKE, KIND_NONE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_TAKE, KIND_NONE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_DONE_WATCH, KIND_NONE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_OBSERVE, KIND_NONE, 0, 0, 0, 0, 1'b1, 0));
        issue_command(make_item(CMD_ARM, KIND_BREAK_REAL, 1, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_RUN_DONE, KIND_NONE, 0, 0, 0, 0, 1'b0, 4));
        issue_command(make_item(CMD_DONE_WATCH, KIND_NONE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_RUN_DONE, KIND_NONE, 0, 0, 0, 0, 1'b0, 9));
        issue_command(make_item(CMD_RESET, KIND_NONE, 0, 0, 0, 0, 1'b0, 0));
        issue_command(make_item(CMD_UNUSED_LO, KIND_TRACE, 1, 1, 1, 1, 1'b1, 1));
        issue_command(make_item(CMD_UNUSED_HI, KIND_BREAK_LINEAR, ALL_ONES, ALL_ONES,
                                ALL_ONES, ALL_ONES, 1'b1, ALL_ONES));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) no_gaps = ($urandom_range(3) == 0);
            it = random_command();
            if (it.command == CMD_ARM) armed_target = it.break_address;
            issue_command(it);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d command items and %0d results.", items_accepted,
                 results_seen);
        $display("Stops taken: %0d breakpoint, %0d watchpoint, %0d trace.",
                 stops_taken[REASON_BREAK], stops_taken[REASON_WATCH],
                 stops_taken[REASON_TRACE]);
        if (errors == 0 && outstanding == 0) begin
            $display("debug_stop_controller: match");
        end else begin
            $display("debug_stop_controller: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/dsc_pkg.sv
rtl/dsc_in_stage.sv
rtl/dsc_core.sv
rtl/dsc_out_stage.sv
rtl/debug_stop_controller.sv
sim/debug_stop_controller_checker.sv
sim/debug_stop_controller_tb.sv
